@@ src/uart_baud_divisor_setup_unit_assert.svh @@
// Assertion macros for the baud divisor setup unit.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef UART_BAUD_DIVISOR_SETUP_UNIT_ASSERT_SVH
`define UART_BAUD_DIVISOR_SETUP_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UBD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define UBD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UBD_ASSERT_IMP(label, ante, cons, msg)
`define UBD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ src/ubd_pkg.sv @@
// Types, constants and control store of the baud divisor setup unit.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ubd_pkg;

    localparam int PCLK_W = 28;
    localparam int BAUD_W = 24;
    localparam int PAR_W  = 2;
    localparam int DATA_W = 4;
    localparam int STOP_W = 2;
    localparam int BYTE_W = 8;

    localparam int CK_W   = PCLK_W - 3;
    localparam int BD_W   = BAUD_W + 8;
    localparam int SB_W   = BAUD_W + 2;
    localparam int Q_W    = 9;
    localparam int DIVD_W = 34;
    localparam int DVS_W  = SB_W;
    localparam int CNT_W  = 6;
    localparam int MUL_W  = SB_W + Q_W;
    localparam int STEP_W = 5;

    localparam logic [PCLK_W-1:0] PCLK_RESET = 28'd60000000;
    localparam logic [BYTE_W-1:0] CARD_SHORT = 8'hF2;
    localparam logic [BYTE_W-1:0] CARD_NINE  = 8'hE2;
    localparam logic [DATA_W-1:0] DATA_SEVEN = 4'd7;
    localparam logic [DATA_W-1:0] DATA_NINE  = 4'd9;
    localparam int                HUNDRED    = 100;
    localparam int                Q_MAX      = 256;
    localparam int                MOD_SHIFT  = 9;

    localparam logic [BYTE_W-1:0] MODE_CHR  = 8'h40;
    localparam logic [BYTE_W-1:0] MODE_PE   = 8'h20;
    localparam logic [BYTE_W-1:0] MODE_PM   = 8'h10;
    localparam logic [BYTE_W-1:0] MODE_STOP = 8'h08;
    localparam logic [BYTE_W-1:0] MODE_MP   = 8'h04;
    localparam logic [BYTE_W-1:0] EXT_BGDM  = 8'h40;
    localparam logic [BYTE_W-1:0] EXT_ABCS  = 8'h10;
    localparam logic [BYTE_W-1:0] EXT_BRME  = 8'h04;

    localparam logic [PAR_W-1:0] PARITY_NONE = 2'd0;
    localparam logic [PAR_W-1:0] PARITY_ODD  = 2'd1;
    localparam logic [PAR_W-1:0] PARITY_EVEN = 2'd2;
    localparam logic [PAR_W-1:0] PARITY_MP   = 2'd3;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_INIT,
        OP_QUARTER,
        OP_HALF,
        OP_FULL,
        OP_SCALE,
        OP_DIV_Q,
        OP_TAKE_Q,
        OP_MUL_CK,
        OP_DIV_DEV,
        OP_DEV,
        OP_BRME,
        OP_MUL_SQ,
        OP_DIV_M,
        OP_MOD,
        OP_FINISH
    } ubd_op_t;

    typedef enum logic [2:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_CK_LE_BD,
        CND_CK4_LE_BD,
        CND_N_LT2,
        CND_RANGE,
        CND_NO_MOD
    } ubd_cond_t;

    typedef struct packed {
        ubd_op_t             op;
        ubd_cond_t           cond;
        logic                wait_div;
        logic [STEP_W-1:0]   target;
    } ubd_uword_t;

    localparam logic [STEP_W-1:0] S_INIT     = 5'd0;
    localparam logic [STEP_W-1:0] S_FULL_CHK = 5'd1;
    localparam logic [STEP_W-1:0] S_QTR_CHK  = 5'd2;
    localparam logic [STEP_W-1:0] S_QUARTER  = 5'd3;
    localparam logic [STEP_W-1:0] S_HALF     = 5'd4;
    localparam logic [STEP_W-1:0] S_FULL     = 5'd5;
    localparam logic [STEP_W-1:0] S_SCALE    = 5'd6;
    localparam logic [STEP_W-1:0] S_DIV_Q    = 5'd7;
    localparam logic [STEP_W-1:0] S_WAIT_Q   = 5'd8;
    localparam logic [STEP_W-1:0] S_TAKE_Q   = 5'd9;
    localparam logic [STEP_W-1:0] S_MUL_CK   = 5'd10;
    localparam logic [STEP_W-1:0] S_DIV_DEV  = 5'd11;
    localparam logic [STEP_W-1:0] S_WAIT_DEV = 5'd12;
    localparam logic [STEP_W-1:0] S_DEV      = 5'd13;
    localparam logic [STEP_W-1:0] S_BRME     = 5'd14;
    localparam logic [STEP_W-1:0] S_MUL_SQ   = 5'd15;
    localparam logic [STEP_W-1:0] S_DIV_M    = 5'd16;
    localparam logic [STEP_W-1:0] S_WAIT_M   = 5'd17;
    localparam logic [STEP_W-1:0] S_MOD      = 5'd18;
    localparam logic [STEP_W-1:0] S_FINISH   = 5'd19;

    function automatic ubd_uword_t ubd_ucode(input logic [STEP_W-1:0] addr);
        ubd_uword_t w;
        w.op       = OP_NOP;
        w.cond     = CND_NEVER;
        w.wait_div = 1'b0;
        w.target   = S_INIT;
        unique case (addr)
            S_INIT:     w.op = OP_INIT;
            S_FULL_CHK:
            begin
                w.cond   = CND_CK_LE_BD;
                w.target = S_FULL;
            end
            S_QTR_CHK:
            begin
                w.cond   = CND_CK4_LE_BD;
                w.target = S_HALF;
            end
            S_QUARTER:
            begin
                w.op     = OP_QUARTER;
                w.cond   = CND_N_LT2;
                w.target = S_QTR_CHK;
            end
            S_HALF:
            begin
                w.op     = OP_HALF;
                w.cond   = CND_ALWAYS;
                w.target = S_SCALE;
            end
            S_FULL:     w.op = OP_FULL;
            S_SCALE:    w.op = OP_SCALE;
            S_DIV_Q:    w.op = OP_DIV_Q;
            S_WAIT_Q:   w.wait_div = 1'b1;
            S_TAKE_Q:
            begin
                w.op     = OP_TAKE_Q;
                w.cond   = CND_RANGE;
                w.target = S_FINISH;
            end
            S_MUL_CK:   w.op = OP_MUL_CK;
            S_DIV_DEV:  w.op = OP_DIV_DEV;
            S_WAIT_DEV: w.wait_div = 1'b1;
            S_DEV:      w.op = OP_DEV;
            S_BRME:
            begin
                w.op     = OP_BRME;
                w.cond   = CND_NO_MOD;
                w.target = S_FINISH;
            end
            S_MUL_SQ:   w.op = OP_MUL_SQ;
            S_DIV_M:    w.op = OP_DIV_M;
            S_WAIT_M:   w.wait_div = 1'b1;
            S_MOD:      w.op = OP_MOD;
            S_FINISH:   w.op = OP_FINISH;
            default:    w.op = OP_NOP;
        endcase
        return w;
    endfunction

    function automatic logic [BYTE_W-1:0] ubd_parity_bits(input logic [PAR_W-1:0] par);
        logic [BYTE_W-1:0] bits;
        unique case (par)
            PARITY_NONE: bits = '0;
            PARITY_ODD:  bits = MODE_PE | MODE_PM;
            PARITY_EVEN: bits = MODE_PE;
            PARITY_MP:   bits = MODE_MP;
            default:     bits = '0;
        endcase
        return bits;
    endfunction

endpackage
`default_nettype wire

@@ src/ubd_if.sv @@
// Channel interfaces of the baud divisor setup unit: request, response, config.
// Depends on ubd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface ubd_req_if;
    import ubd_pkg::*;
    logic                valid;
    logic                ready;
    logic [BAUD_W-1:0]   baud_rate;
    logic [PAR_W-1:0]    parity_mode;
    logic [DATA_W-1:0]   data_bits;
    logic [STOP_W-1:0]   stop_bits;
    modport source (output valid, baud_rate, parity_mode, data_bits, stop_bits, input ready);
    modport sink (input valid, baud_rate, parity_mode, data_bits, stop_bits, output ready);
endinterface

interface ubd_rsp_if;
    import ubd_pkg::*;
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   mode_reg;
    logic [BYTE_W-1:0]   card_reg;
    logic [BYTE_W-1:0]   ext_mode_reg;
    logic [BYTE_W-1:0]   rate_reg;
    logic [BYTE_W-1:0]   modulation_reg;
    logic                range_error;
    modport source (output valid, mode_reg, card_reg, ext_mode_reg, rate_reg,
                    modulation_reg, range_error, input ready);
    modport sink (input valid, mode_reg, card_reg, ext_mode_reg, rate_reg,
                  modulation_reg, range_error, output ready);
endinterface

interface ubd_cfg_if;
    import ubd_pkg::*;
    logic                valid;
    logic                ready;
    logic [PCLK_W-1:0]   pclk_hz;
    modport source (output valid, pclk_hz, input ready);
    modport sink (input valid, pclk_hz, output ready);
endinterface
`default_nettype wire

@@ src/uart_baud_divisor_setup_unit.sv @@
// UART baud divisor setup unit: microcoded sequencer over a shared divider.
// Depends on ubd_pkg, the interfaces in ubd_if.sv and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "uart_baud_divisor_setup_unit_assert.svh"
// One request gives one response of five register bytes and a range flag. The
// sequencer steps through its control store, runs up to three prescaler loop rounds
// and makes up to three passes of one restoring divider (clock over scaled rate,
// deviation, modulation word); it ends after the first pass when the divider ratio
// is out of range and after the second pass without modulation. A new request
// can transfer in the cycle after the sequencer finishes, while the previous response
// still waits in the output register; a response that is not taken holds the
// sequencer at its last step.
// Config writes are always ready and take effect at once; write them only while no
// request is in flight.
module uart_baud_divisor_setup_unit (
    input  wire        clk,
    input  wire        rst_n,
    ubd_cfg_if.sink    cfg,
    ubd_req_if.sink    req,
    ubd_rsp_if.source  rsp
);
    import ubd_pkg::*;

    logic [PCLK_W-1:0]  pclk_reg;
    logic               busy_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               out_valid_reg;

    logic [BAUD_W-1:0]  baud_reg;
    logic [PAR_W-1:0]   par_reg;
    logic [DATA_W-1:0]  data_reg;
    logic [STOP_W-1:0]  stop_reg;

    logic [CK_W-1:0]    ck_reg;
    logic [1:0]         n_reg;
    logic               bgdm_reg;
    logic               abcs_reg;
    logic               brme_reg;
    logic [SB_W-1:0]    sb_reg;
    logic [Q_W-1:0]     q_reg;
    logic [MUL_W-1:0]   mul_reg;
    logic [MUL_W-1:0]   dev_reg;
    logic [BYTE_W-1:0]  rate_val_reg;
    logic [BYTE_W-1:0]  mddr_val_reg;
    logic               rerr_val_reg;

    logic [BYTE_W-1:0]  mode_out_reg;
    logic [BYTE_W-1:0]  card_out_reg;
    logic [BYTE_W-1:0]  ext_out_reg;
    logic [BYTE_W-1:0]  rate_out_reg;
    logic [BYTE_W-1:0]  mddr_out_reg;
    logic               rerr_out_reg;

    logic [DIVD_W-1:0]  div_quo_reg;
    logic [DVS_W-1:0]   div_rem_reg;
    logic [DVS_W-1:0]   div_dvs_reg;
    logic [CNT_W-1:0]   div_cnt_reg;
    logic               div_busy_reg;

    ubd_uword_t         ucw;
    logic               in_xfer;
    logic               hold;
    logic               run;
    logic               cond_hit;
    logic               div_start;
    logic [DIVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]   div_divisor;
    logic [DVS_W:0]     div_trial;
    logic [DVS_W:0]     div_diff;
    logic [BD_W-1:0]    bd;
    logic               q_out_of_range;
    logic [10:0]        m_round;
    logic [9:0]         m_half;

    assign ucw       = ubd_ucode(step_reg);
    assign in_xfer   = req.valid && req.ready;
    assign req.ready = !busy_reg;
    assign cfg.ready = 1'b1;
    assign bd        = {baud_reg, 8'b0};

    assign hold = (ucw.wait_div && div_busy_reg)
               || (ucw.op == OP_FINISH && out_valid_reg && !rsp.ready);
    assign run  = busy_reg && !hold;

    assign q_out_of_range = (div_quo_reg == '0) || (div_quo_reg > DIVD_W'(Q_MAX));

    always_comb
    begin
        case (ucw.cond)
            CND_NEVER:     cond_hit = 1'b0;
            CND_ALWAYS:    cond_hit = 1'b1;
            CND_CK_LE_BD:  cond_hit = BD_W'(ck_reg) <= bd;
            CND_CK4_LE_BD: cond_hit = BD_W'(ck_reg[CK_W-1:2]) <= bd;
            CND_N_LT2:     cond_hit = n_reg < 2'd2;
            CND_RANGE:     cond_hit = q_out_of_range;
            CND_NO_MOD:    cond_hit = MUL_W'(sb_reg) > dev_reg;
            default:       cond_hit = 1'b0;
        endcase
        step_next = cond_hit ? ucw.target : step_reg + STEP_W'(1);
    end

    // sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pclk_reg      <= PCLK_RESET;
            busy_reg      <= 1'b0;
            step_reg      <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                pclk_reg <= cfg.pclk_hz;
            end
            if (in_xfer)
            begin
                busy_reg <= 1'b1;
                step_reg <= S_INIT;
            end
            else if (run)
            begin
                if (ucw.op == OP_FINISH)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_next;
                end
            end
            if (run && ucw.op == OP_FINISH)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            baud_reg <= req.baud_rate;
            par_reg  <= req.parity_mode;
            data_reg <= req.data_bits;
            stop_reg <= req.stop_bits;
        end
        if (run)
        begin
            unique case (ucw.op)
                OP_NOP: ;
                OP_INIT:
                begin
                    ck_reg       <= pclk_reg[PCLK_W-1:3];
                    n_reg        <= 2'd0;
                    bgdm_reg     <= 1'b0;
                    abcs_reg     <= 1'b0;
                    brme_reg     <= 1'b0;
                    mddr_val_reg <= '0;
                end
                OP_QUARTER:
                begin
                    ck_reg <= ck_reg >> 2;
                    n_reg  <= n_reg + 2'd1;
                end
                OP_HALF:    bgdm_reg <= BD_W'(ck_reg[CK_W-1:1]) <= bd;
                OP_FULL:
                begin
                    bgdm_reg <= 1'b1;
                    abcs_reg <= 1'b1;
                end
                OP_SCALE:
                    sb_reg <= SB_W'(baud_reg) << ({1'b0, !bgdm_reg} + {1'b0, !abcs_reg});
                OP_DIV_Q: ;
                OP_TAKE_Q:
                begin
                    q_reg        <= div_quo_reg[Q_W-1:0];
                    rerr_val_reg <= q_out_of_range;
                    if (div_quo_reg == '0)
                    begin
                        rate_val_reg <= '0;
                    end
                    else if (q_out_of_range)
                    begin
                        rate_val_reg <= '1;
                    end
                    else
                    begin
                        rate_val_reg <= BYTE_W'(div_quo_reg[Q_W-1:0] - Q_W'(1));
                    end
                end
                OP_MUL_CK:  mul_reg <= MUL_W'(ck_reg) * MUL_W'(HUNDRED);
                OP_DIV_DEV: mul_reg <= MUL_W'(sb_reg) * MUL_W'(HUNDRED);
                OP_DEV:     dev_reg <= MUL_W'(div_quo_reg) - mul_reg;
                OP_BRME:    brme_reg <= MUL_W'(sb_reg) <= dev_reg;
                OP_MUL_SQ:  mul_reg <= MUL_W'(sb_reg) * MUL_W'(q_reg);
                OP_DIV_M: ;
                OP_MOD:
                begin
                    if (div_quo_reg[DIVD_W-1:10] != '0 || m_half > 10'd255)
                    begin
                        mddr_val_reg <= '1;
                    end
                    else
                    begin
                        mddr_val_reg <= m_half[BYTE_W-1:0];
                    end
                end
                OP_FINISH:
                begin
                    mode_out_reg <= {6'b0, n_reg}
                                  | ((stop_reg[0]) ? '0 : MODE_STOP)
                                  | ubd_parity_bits(par_reg)
                                  | ((data_reg == DATA_SEVEN) ? MODE_CHR : '0);
                    card_out_reg <= (data_reg < DATA_NINE) ? CARD_SHORT : CARD_NINE;
                    ext_out_reg  <= (bgdm_reg ? EXT_BGDM : '0)
                                  | (abcs_reg ? EXT_ABCS : '0)
                                  | (brme_reg ? EXT_BRME : '0);
                    rate_out_reg <= rate_val_reg;
                    mddr_out_reg <= mddr_val_reg;
                    rerr_out_reg <= rerr_val_reg;
                end
                default: ;
            endcase
        end
    end

    assign m_round = 11'(div_quo_reg[9:0]) + 11'd1;
    assign m_half  = m_round[10:1];

    // shared restoring divider
    assign div_start = run && (ucw.op == OP_DIV_Q || ucw.op == OP_DIV_DEV
                            || ucw.op == OP_DIV_M);

    always_comb
    begin
        unique case (ucw.op)
            OP_DIV_DEV:
            begin
                div_dividend = DIVD_W'(mul_reg[BD_W-1:0]);
                div_divisor  = DVS_W'(q_reg);
            end
            OP_DIV_M:
            begin
                div_dividend = {mul_reg[CK_W-1:0], MOD_SHIFT'(0)};
                div_divisor  = DVS_W'(ck_reg);
            end
            default:
            begin
                div_dividend = DIVD_W'(ck_reg);
                div_divisor  = sb_reg;
            end
        endcase
        div_trial = {div_rem_reg, div_quo_reg[DIVD_W-1]};
        div_diff  = div_trial - {1'b0, div_dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= CNT_W'(DIVD_W);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg  <= div_cnt_reg - CNT_W'(1);
            div_busy_reg <= div_cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            div_quo_reg <= div_dividend;
            div_rem_reg <= '0;
            div_dvs_reg <= div_divisor;
        end
        else if (div_busy_reg)
        begin
            if (div_trial >= {1'b0, div_dvs_reg})
            begin
                div_rem_reg <= div_diff[DVS_W-1:0];
                div_quo_reg <= {div_quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_reg <= div_trial[DVS_W-1:0];
                div_quo_reg <= {div_quo_reg[DIVD_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.mode_reg       = mode_out_reg;
    assign rsp.card_reg       = card_out_reg;
    assign rsp.ext_mode_reg   = ext_out_reg;
    assign rsp.rate_reg       = rate_out_reg;
    assign rsp.modulation_reg = mddr_out_reg;
    assign rsp.range_error    = rerr_out_reg;

    `UBD_ASSERT_IMP(a_div_inside_job, div_busy_reg, busy_reg, "divider runs while idle")
    `UBD_ASSERT_IMP(a_div_no_restart, div_start, !div_busy_reg, "divider restarted")
    `UBD_ASSERT_IMP(a_range_no_mod, rerr_out_reg, mddr_out_reg == '0, "mod word on range error")
    `UBD_ASSERT_IMP(a_range_no_brme, rerr_out_reg, (ext_out_reg & EXT_BRME) == '0, "BRME on range")
    `UBD_ASSERT_NEXT(a_xfer_starts, in_xfer, busy_reg && step_reg == S_INIT, "not started")

endmodule
`default_nettype wire
